// ===== sv/drc_pkg.sv =====
// Shared types, constants and table builders for the dynamic range compressor.
`timescale 1ns / 1ps

package drc_pkg;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int LVL_W   = 17;
    localparam int TGT_W   = 26;
    localparam int ENV_W   = 24;
    localparam int DIF_W   = 27;
    localparam int N_W     = 20;
    localparam int GAIN_W  = 31;
    localparam int GR_W    = 15;
    localparam int CFG_W   = 16;

    localparam logic signed [CFG_W-1:0] THRESHOLD_RESET = -16'sd5120;
    localparam logic [CFG_W-1:0]        SLOPE_RESET     = 16'd49152;
    localparam logic [CFG_W-1:0]        ATTACK_RESET    = 16'd65388;
    localparam logic [CFG_W-1:0]        RELEASE_RESET   = 16'd65521;

    localparam logic signed [LVL_W-1:0] LEVEL_FLOOR = -17'sd35328;
    localparam logic [17:0]             LEVEL_FLOOR_MAG = 18'd35328;
    localparam logic signed [ENV_W-1:0] ENV_RESET = -24'sd7864320;
    localparam logic signed [ENV_W-1:0] ENV_MIN   = -24'sd3932160;
    localparam logic [MUL_B_W-1:0]      DB_PER_LOG2 = 32'd394567;
    localparam logic signed [MUL_B_W-1:0] NEG_LOG2_PER_DB = -32'sd10885;
    localparam logic [GAIN_W-1:0]       GAIN_ONE = 31'h4000_0000;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SLOPE     = 2'd1,
        REG_ATTACK    = 2'd2,
        REG_RELEASE   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_IDX, S_ROM, S_LVL, S_LVLW, S_TGT, S_TGTW, S_DIFF,
        S_ENVM, S_ENVW, S_EXPM, S_EXPW, S_GSTEP, S_GUPD, S_SHIFT, S_OUTM, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_NORM, OP_IDX, OP_ROM, OP_LVL, OP_LVLW, OP_TGT,
        OP_TGTW, OP_DIFF, OP_ENVM, OP_ENVW, OP_EXPM, OP_EXPW, OP_GMUL,
        OP_GUPD, OP_SHIFT, OP_OUTM, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
    } cmd_t;

    typedef struct packed {
        logic n_bit;
    } status_t;

    function automatic logic [15:0] log2_frac(input logic [63:0] m_in);
        logic [63:0] m;
        logic [15:0] res;
        m = m_in;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            res = {res[14:0], 1'b0};
            if (m >= 64'h8000_0000)
            begin
                res[0] = 1'b1;
                m = m >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [29:0] root_entry(input int j);
        logic [63:0] r;
        r = isqrt64(64'h0800_0000_0000_0000);
        for (int i = 1; i < 16; i++)
        begin
            if (i <= j)
            begin
                r = isqrt64(r << 30);
            end
        end
        return r[29:0];
    endfunction

endpackage

// ===== sv/audio_dynamic_range_compressor.sv =====
// Top level of the feed-forward hard-knee audio compressor.
//
// Input channel: sample_in with in_valid; the block drives in_stall and takes
// a transfer at a rising edge where in_valid is high and in_stall is low.
// Output channel: sample_out and gain_reduction_db with out_valid; the sink
// drives out_stall, and a result stays put while stalled.
// Each sample runs through one shared multiplier in a fixed sequence, with a
// gain loop of sixteen steps that adds an update step for each set bit of the
// exponent. No new sample is taken until the current one has been processed.
// The block takes the next sample while a result waits in the output
// register; it then holds its final step until the sink frees that register.
// Reset loads the default registers and sets the envelope to -120 dB.
// The configuration port is written with cfg_we, cfg_index and cfg_data; the user
// must write it only while no sample is in flight, which the block does not enforce.
`timescale 1ns / 1ps

module audio_dynamic_range_compressor
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int LOG_TABLE_SIZE = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_WIDTH-1:0]   sample_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_WIDTH-1:0]   sample_out,
    output logic [drc_pkg::GR_W-1:0]  gain_reduction_db,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [drc_pkg::CFG_W-1:0] cfg_data
);
    import drc_pkg::*;

    cmd_t    cmd;
    status_t status;

    drc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    drc_dpath
    #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .LOG_TABLE_SIZE (LOG_TABLE_SIZE)
    )
    u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .sample_in         (sample_in),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample_out        (sample_out),
        .gain_reduction_db (gain_reduction_db)
    );

endmodule

// ===== sv/drc_ctrl.sv =====
// Sequencer for the compressor: steps the datapath through one sample.
`timescale 1ns / 1ps

module drc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  drc_pkg::status_t status,
    output drc_pkg::cmd_t   cmd
);
    import drc_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_IDLE;
        cmd.step       = step_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_NORM;
                end
            end
            S_NORM:  begin cmd.op = OP_NORM; state_next = S_IDX;  end
            S_IDX:   begin cmd.op = OP_IDX;  state_next = S_ROM;  end
            S_ROM:   begin cmd.op = OP_ROM;  state_next = S_LVL;  end
            S_LVL:   begin cmd.op = OP_LVL;  state_next = S_LVLW; end
            S_LVLW:  begin cmd.op = OP_LVLW; state_next = S_TGT;  end
            S_TGT:   begin cmd.op = OP_TGT;  state_next = S_TGTW; end
            S_TGTW:  begin cmd.op = OP_TGTW; state_next = S_DIFF; end
            S_DIFF:  begin cmd.op = OP_DIFF; state_next = S_ENVM; end
            S_ENVM:  begin cmd.op = OP_ENVM; state_next = S_ENVW; end
            S_ENVW:  begin cmd.op = OP_ENVW; state_next = S_EXPM; end
            S_EXPM:  begin cmd.op = OP_EXPM; state_next = S_EXPW; end
            S_EXPW:
            begin
                cmd.op     = OP_EXPW;
                step_next  = '0;
                state_next = S_GSTEP;
            end
            S_GSTEP:
            begin
                cmd.op = OP_GMUL;
                if (status.n_bit)
                begin
                    state_next = S_GUPD;
                end
                else if (step_reg == 4'd15)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_GUPD:
            begin
                cmd.op = OP_GUPD;
                if (step_reg == 4'd15)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_GSTEP;
                end
            end
            S_SHIFT: begin cmd.op = OP_SHIFT; state_next = S_OUTM; end
            S_OUTM:  begin cmd.op = OP_OUTM;  state_next = S_OUT;  end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.op = OP_OUTM;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_NORM))
        else $error("accepted transfer did not start the sequence");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("result overwrote a stalled output");
    a_gupd_after_gstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GUPD) |-> ($past(state_reg) == S_GSTEP))
        else $error("gain update without a multiply step");
`endif

endmodule

// ===== sv/drc_dpath.sv =====
// Datapath for the compressor: level, gain computer, envelope and antilog.
`timescale 1ns / 1ps

module drc_dpath
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int LOG_TABLE_SIZE = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  drc_pkg::cmd_t                  cmd,
    output drc_pkg::status_t               status,
    input  logic [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]      cfg_data,
    output logic [SAMPLE_WIDTH-1:0]        sample_out,
    output logic [drc_pkg::GR_W-1:0]       gain_reduction_db
);
    import drc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int E_W   = $clog2(SW);
    localparam int IDX_W = $clog2(LOG_TABLE_SIZE);
    localparam int NL_W  = E_W + 16;

    logic [15:0] log_rom [LOG_TABLE_SIZE];
    logic [29:0] root_rom [16];

    for (genvar k = 0; k < LOG_TABLE_SIZE; k++)
    begin : g_log
        localparam logic [63:0] FR  = (64'(k) << 30) / LOG_TABLE_SIZE;
        localparam logic [15:0] ENT = log2_frac(64'h4000_0000 + FR);
        assign log_rom[k] = ENT;
    end

    for (genvar j = 0; j < 16; j++)
    begin : g_root
        localparam logic [29:0] ENT = root_entry(j);
        assign root_rom[j] = ENT;
    end

    logic signed [CFG_W-1:0] thr_reg, thr_next;
    logic [CFG_W-1:0]        slope_reg, slope_next;
    logic [CFG_W-1:0]        att_reg, att_next;
    logic [CFG_W-1:0]        rel_reg, rel_next;
    logic signed [ENV_W-1:0] env_reg, env_next;

    logic [SW-1:0]            mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic                     zero_reg, zero_next;
    logic [E_W-1:0]           e_reg, e_next;
    logic [29:0]              frac_reg, frac_next;
    logic [15:0]              logq_reg, logq_next;
    logic signed [LVL_W-1:0]  level_reg, level_next;
    logic signed [TGT_W-1:0]  target_reg, target_next;
    logic [CFG_W-1:0]         c_reg, c_next;
    logic signed [DIF_W-1:0]  d_reg, d_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [SW-1:0]            yout_reg, yout_next;
    logic [GR_W-1:0]          gr_reg, gr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RESET;
            slope_reg <= SLOPE_RESET;
            att_reg   <= ATTACK_RESET;
            rel_reg   <= RELEASE_RESET;
            env_reg   <= ENV_RESET;
        end
        else
        begin
            thr_reg   <= thr_next;
            slope_reg <= slope_next;
            att_reg   <= att_next;
            rel_reg   <= rel_next;
            env_reg   <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        logq_reg   <= logq_next;
        level_reg  <= level_next;
        target_reg <= target_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        n_reg      <= n_next;
        gain_reg   <= gain_next;
        prod_reg   <= mul_a * mul_b;
        yout_reg   <= yout_next;
        gr_reg     <= gr_next;
    end

    always_comb
    begin
        thr_next   = thr_reg;
        slope_next = slope_reg;
        att_next   = att_reg;
        rel_next   = rel_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_THRESHOLD: thr_next   = $signed(cfg_data);
                REG_SLOPE:     slope_next = cfg_data;
                REG_ATTACK:    att_next   = cfg_data;
                REG_RELEASE:   rel_next   = cfg_data;
                default:       thr_next   = thr_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [E_W-1:0]           p;
        logic [SW-1:0]            norm;
        logic [SW+28:0]           ext;
        logic [IDX_W-1:0]         idx;
        logic [NL_W-1:0]          negl;
        logic [41:0]              lsum;
        logic [17:0]              lvmag;
        logic signed [LVL_W:0]    diff;
        logic [33:0]              tsum;
        logic [TGT_W-1:0]         tmag;
        logic signed [44:0]       s;
        logic signed [28:0]       e29;
        logic [61:0]              gsum;
        logic [62:0]              osum;
        logic [32:0]              ymag;
        logic signed [ENV_W:0]    esum;

        mag_next    = mag_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        e_next      = e_reg;
        frac_next   = frac_reg;
        logq_next   = logq_reg;
        level_next  = level_reg;
        target_next = target_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        n_next      = n_reg;
        gain_next   = gain_reg;
        env_next    = env_reg;
        yout_next   = yout_reg;
        gr_next     = gr_reg;
        mul_a       = '0;
        mul_b       = '0;

        p = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (mag_reg[i])
            begin
                p = E_W'(i);
            end
        end
        norm  = mag_reg << (E_W'(SW - 1) - p);
        ext   = {norm[SW-2:0], 30'b0};
        idx   = prod_reg[30 +: IDX_W];
        negl  = {e_reg, 16'b0} - NL_W'(logq_reg);
        lsum  = {1'b0, prod_reg[40:0]} + 42'h80_0000;
        lvmag = lsum[41:24];
        diff  = (LVL_W+1)'(level_reg) - (LVL_W+1)'(thr_reg);
        tsum  = {1'b0, prod_reg[32:0]} + 34'd128;
        tmag  = tsum[33:8];
        s     = $signed(prod_reg[44:0]) + 45'($signed({target_reg, 16'b0})) + 45'sd32768;
        e29   = s[44:16];
        gsum  = {1'b0, prod_reg[60:0]} + 62'h2000_0000;
        osum  = {1'b0, prod_reg[61:0]} + 63'h2000_0000;
        ymag  = osum[62:30];
        esum  = (ENV_W+1)'(env_reg) + 25'sd128;

        unique case (cmd.op)
            OP_IDLE: ;
            OP_LOAD:
            begin
                neg_next = sample_in[SW-1];
                mag_next = sample_in[SW-1] ? (~sample_in + SW'(1)) : sample_in;
            end
            OP_NORM:
            begin
                zero_next = (mag_reg == '0);
                e_next    = E_W'(SW - 1) - p;
                frac_next = ext[SW+28 -: 30];
            end
            OP_IDX:
            begin
                mul_a = MUL_A_W'(frac_reg);
                mul_b = MUL_B_W'(LOG_TABLE_SIZE);
            end
            OP_ROM:  logq_next = log_rom[idx];
            OP_LVL:
            begin
                mul_a = MUL_A_W'(negl);
                mul_b = $signed(DB_PER_LOG2);
            end
            OP_LVLW:
            begin
                if (zero_reg || lvmag > LEVEL_FLOOR_MAG)
                begin
                    level_next = LEVEL_FLOOR;
                end
                else
                begin
                    level_next = -$signed(lvmag[LVL_W-1:0]);
                end
            end
            OP_TGT:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'(slope_reg);
            end
            OP_TGTW:
            begin
                if (level_reg > LVL_W'(thr_reg))
                begin
                    target_next = -$signed(tmag);
                end
                else
                begin
                    target_next = '0;
                end
            end
            OP_DIFF:
            begin
                c_next = (target_reg < TGT_W'(env_reg)) ? att_reg : rel_reg;
                d_next = DIF_W'(env_reg) - DIF_W'(target_reg);
            end
            OP_ENVM:
            begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'(c_reg);
            end
            OP_ENVW:
            begin
                if (e29 < 29'(ENV_MIN))
                begin
                    env_next = ENV_MIN;
                end
                else if (e29 > 29'sd0)
                begin
                    env_next = '0;
                end
                else
                begin
                    env_next = e29[ENV_W-1:0];
                end
            end
            OP_EXPM:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = NEG_LOG2_PER_DB;
            end
            OP_EXPW:
            begin
                n_next    = prod_reg[16 +: N_W];
                gain_next = GAIN_ONE;
            end
            OP_GMUL:
            begin
                mul_a = MUL_A_W'(gain_reg);
                mul_b = MUL_B_W'(root_rom[cmd.step]);
            end
            OP_GUPD:  gain_next = gsum[60:30];
            OP_SHIFT: gain_next = gain_reg >> n_reg[N_W-1:16];
            OP_OUTM:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            OP_OUT:
            begin
                if (!neg_reg)
                begin
                    if (ymag > 33'({1'b0, {(SW-1){1'b1}}}))
                    begin
                        yout_next = {1'b0, {(SW-1){1'b1}}};
                    end
                    else
                    begin
                        yout_next = ymag[SW-1:0];
                    end
                end
                else
                begin
                    if (ymag > 33'({1'b1, {(SW-1){1'b0}}}))
                    begin
                        yout_next = {1'b1, {(SW-1){1'b0}}};
                    end
                    else
                    begin
                        yout_next = ~ymag[SW-1:0] + SW'(1);
                    end
                end
                gr_next = esum[22:8];
            end
            default: ;
        endcase
    end

    assign status.n_bit      = n_reg[4'd15 - cmd.step];
    assign sample_out        = yout_reg;
    assign gain_reduction_db = gr_reg;

endmodule

// ===== tb/tb_audio_dynamic_range_compressor.sv =====
// Self-checking testbench for the audio dynamic range compressor, with its own gain predictor.
`timescale 1ns / 1ps

module tb_audio_dynamic_range_compressor;
    import drc_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic [23:0] smp;
        logic [14:0] gr;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [23:0]       sample_in;
    logic              out_valid;
    logic              out_stall;
    logic [23:0]       sample_out;
    logic [GR_W-1:0]   gain_reduction_db;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    logic [23:0] pending_samples[$];
    result_t     expected_results[$];
    int          mismatches;
    int          cycles;
    int          idle_pct;
    int          stall_pct;
    bit          hold_tx;

    longint      threshold_q;
    longint      slope_q;
    longint      attack_q;
    longint      release_q;
    longint      envelope_q;
    longint      log_tab[256];
    longint      root_tab[16];

    audio_dynamic_range_compressor u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .gain_reduction_db(gain_reduction_db),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint sqrt_floor(input longint v);
        longint r;
        longint cand;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = r | (longint'(1) << i);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic longint frac_log2(input longint m_in);
        longint m;
        longint res;
        m = m_in;
        res = 0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            res = res << 1;
            if (m >= (longint'(2) << 30))
            begin
                res = res | 1;
                m = m >> 1;
            end
        end
        return res;
    endfunction

    function automatic result_t compress(input logic [23:0] x);
        longint  magv;
        longint  m;
        longint  negl;
        longint  lvl;
        longint  tgt;
        longint  c;
        longint  s;
        longint  e;
        longint  n;
        longint  gain;
        longint  y;
        int      p;
        bit      neg;
        result_t r;
        neg = x[23];
        magv = neg ? (longint'(1) << 24) - longint'(x) : longint'(x);
        if (magv == 0)
            lvl = -35328;
        else
        begin
            p = 23;
            while (magv[p] == 1'b0)
                p--;
            m = magv << (30 - p);
            negl = (longint'(23 - p) << 16) - log_tab[(m - (longint'(1) << 30)) >> 22];
            lvl = -((negl * 394567 + (longint'(1) << 23)) >>> 24);
            if (lvl < -35328)
                lvl = -35328;
        end
        tgt = 0;
        if (lvl > threshold_q)
            tgt = -(((lvl - threshold_q) * slope_q + 128) >>> 8);
        c = (tgt < envelope_q) ? attack_q : release_q;
        s = c * envelope_q + (65536 - c) * tgt + 32768;
        e = s >>> 16;
        if (e < -3932160)
            e = -3932160;
        if (e > 0)
            e = 0;
        envelope_q = e;
        n = (-e * 10885) >>> 16;
        gain = longint'(1) << 30;
        for (int j = 0; j < 16; j++)
            if (n[15 - j])
                gain = (gain * root_tab[j] + (longint'(1) << 29)) >> 30;
        gain = gain >> (n >> 16);
        y = (magv * gain + (longint'(1) << 29)) >> 30;
        if (neg)
            y = -y;
        if (y > 8388607)
            y = 8388607;
        if (y < -8388608)
            y = -8388608;
        r.smp = y[23:0];
        r.gr = 15'((e + 128) >>> 8);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_results.push_back(compress(sample_in));
            if (pending_samples.size() > 0 && !hold_tx && $urandom_range(99) >= idle_pct)
            begin
                sample_in <= pending_samples.pop_front();
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: sample_out=%h gain_reduction_db=%h",
                                 sample_out, gain_reduction_db);
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (want.smp !== sample_out || want.gr !== gain_reduction_db)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: sample_out exp %h got %h, gain exp %h got %h",
                                     want.smp, sample_out, want.gr, gain_reduction_db);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_THRESHOLD: threshold_q = longint'($signed(v));
            REG_SLOPE:     slope_q = longint'(v);
            REG_ATTACK:    attack_q = longint'(v);
            REG_RELEASE:   release_q = longint'(v);
            default:       ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int thr, input int slp, input int atk, input int rel);
        write_reg(REG_THRESHOLD, thr[15:0]);
        write_reg(REG_SLOPE, slp[15:0]);
        write_reg(REG_ATTACK, atk[15:0]);
        write_reg(REG_RELEASE, rel[15:0]);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_results.size() > 0 || in_valid)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    initial
    begin
        logic signed [23:0] x;
        int sh;
        mismatches = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_tx = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = '0;
        threshold_q = -5120;
        slope_q = 49152;
        attack_q = 65388;
        release_q = 65521;
        envelope_q = -7864320;
        for (int k = 0; k < 256; k++)
            log_tab[k] = frac_log2((longint'(1) << 30) + ((longint'(k) << 30) / 256));
        root_tab[0] = sqrt_floor(longint'(1) << 59);
        for (int j = 1; j < 16; j++)
            root_tab[j] = sqrt_floor(root_tab[j - 1] << 30);
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, zero, full-scale negative, loud burst then quiet for attack and release
        pending_samples.push_back(24'h000000);
        pending_samples.push_back(24'h7FFFFF);
        pending_samples.push_back(24'h800000);
        pending_samples.push_back(24'h000001);
        pending_samples.push_back(24'hFFFFFF);
        pending_samples.push_back(24'h0CCCCD);
        pending_samples.push_back(24'hF33333);
        for (int i = 0; i < 8; i++)
            pending_samples.push_back(i[0] ? 24'h800000 : 24'h7FFFFF);
        for (int i = 0; i < 8; i++)
            pending_samples.push_back(24'h000010 << i);
        drain();

        for (int ph = 1; ph <= 8; ph++)
        begin
            case (ph)
                1: configure(0, 65535, 0, 65535);
                2: configure(-30720, 0, 65535, 0);
                3: configure(-12800, 32768, 60000, 64000);
                5: configure(-2560, 65535, 65000, 65500);
                default: configure(-int'($urandom_range(30720)), int'($urandom_range(65535)),
                                   int'($urandom_range(65535)), int'($urandom_range(65535)));
            endcase
            @(negedge clk);
            idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 53 : 27) : 0;
            stall_pct = (ph % 4 == 2) ? 53 : ((ph % 4 == 3) ? 27 : 0);
            for (int i = 0; i < 92; i++)
            begin
                if ($urandom_range(15) == 0)
                    x = ($urandom_range(2) == 0) ? 24'sh000000
                        : (($urandom_range(1) == 0) ? 24'sh7FFFFF : 24'sh800000);
                else
                begin
                    sh = ((i / 12) % 2) ? int'($urandom_range(23, 8)) : int'($urandom_range(3, 0));
                    x = 24'($urandom);
                    x = x >>> sh;
                end
                pending_samples.push_back(x);
            end
            if (ph == 3)
            begin
                while (pending_samples.size() > 46)
                    @(negedge clk);
                hold_tx = 1'b1;
                while (expected_results.size() > 0 || in_valid)
                    @(negedge clk);
                hold_tx = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
